// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the xoodoo permutation core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define XPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, disabled during reset
`define XPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/core/xpc_pkg.sv =====
// ----------------------------------------------------------------------------
// xpc_pkg
// types, widths, config indexes and round constants of the xoodoo core
// ----------------------------------------------------------------------------
package xpc_pkg;

  localparam int LANE_W     = 32;
  localparam int WORD_W     = 64;
  localparam int ROUNDS     = 12;
  localparam int RIDX_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam int THETA_ROT_A    = 5;
  localparam int THETA_ROT_B    = 14;
  localparam int RHO_WEST_ROT   = 11;
  localparam int RHO_EAST_ROT_A = 1;
  localparam int RHO_EAST_ROT_B = 8;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 1'd1;

  localparam logic [RIDX_W-1:0] ROUNDS_MAX  = RIDX_W'(ROUNDS);
  localparam logic [RIDX_W-1:0] ROUND_LAST  = RIDX_W'(ROUNDS - 1);
  localparam logic [3:0]        RC_RESET    = 4'd12;

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t [3:0]       plane_t;
  typedef plane_t [2:0]      lanes_t;
  typedef lane_t [3:0]       parity_t;

  // result of one round, handed from the round unit to the sequencer
  typedef struct packed {
    lanes_t  lanes;
    parity_t parity;
    logic    mismatch;
  } round_res_t;

  function automatic lane_t round_const(logic [RIDX_W-1:0] idx);
    lane_t rc;
    case (idx)
      4'd0:    rc = 32'h0000_0058;
      4'd1:    rc = 32'h0000_0038;
      4'd2:    rc = 32'h0000_03C0;
      4'd3:    rc = 32'h0000_00D0;
      4'd4:    rc = 32'h0000_0120;
      4'd5:    rc = 32'h0000_0014;
      4'd6:    rc = 32'h0000_0060;
      4'd7:    rc = 32'h0000_002C;
      4'd8:    rc = 32'h0000_0380;
      4'd9:    rc = 32'h0000_00F0;
      4'd10:   rc = 32'h0000_01A0;
      4'd11:   rc = 32'h0000_0012;
      default: rc = '0;
    endcase
    return rc;
  endfunction

endpackage

// ===== rtl/core/xpc_feed_if.sv =====
// ----------------------------------------------------------------------------
// xpc_feed_if
// input channel: one full 384-bit state per word
// ----------------------------------------------------------------------------
interface xpc_feed_if;
  logic                       valid;
  logic                       ready;
  logic [xpc_pkg::WORD_W-1:0] in_p0_lanes01;
  logic [xpc_pkg::WORD_W-1:0] in_p0_lanes23;
  logic [xpc_pkg::WORD_W-1:0] in_p1_lanes01;
  logic [xpc_pkg::WORD_W-1:0] in_p1_lanes23;
  logic [xpc_pkg::WORD_W-1:0] in_p2_lanes01;
  logic [xpc_pkg::WORD_W-1:0] in_p2_lanes23;

  modport source (
    output valid, in_p0_lanes01, in_p0_lanes23, in_p1_lanes01, in_p1_lanes23,
           in_p2_lanes01, in_p2_lanes23,
    input  ready
  );
  modport sink (
    input  valid, in_p0_lanes01, in_p0_lanes23, in_p1_lanes01, in_p1_lanes23,
           in_p2_lanes01, in_p2_lanes23,
    output ready
  );
endinterface

// ===== rtl/core/xpc_result_if.sv =====
// ----------------------------------------------------------------------------
// xpc_result_if
// output channel: permuted state plus the sticky fault flag
// ----------------------------------------------------------------------------
interface xpc_result_if;
  logic                       valid;
  logic                       ready;
  logic [xpc_pkg::WORD_W-1:0] out_p0_lanes01;
  logic [xpc_pkg::WORD_W-1:0] out_p0_lanes23;
  logic [xpc_pkg::WORD_W-1:0] out_p1_lanes01;
  logic [xpc_pkg::WORD_W-1:0] out_p1_lanes23;
  logic [xpc_pkg::WORD_W-1:0] out_p2_lanes01;
  logic [xpc_pkg::WORD_W-1:0] out_p2_lanes23;
  logic                       fault_seen;

  modport source (
    output valid, out_p0_lanes01, out_p0_lanes23, out_p1_lanes01, out_p1_lanes23,
           out_p2_lanes01, out_p2_lanes23, fault_seen,
    input  ready
  );
  modport sink (
    input  valid, out_p0_lanes01, out_p0_lanes23, out_p1_lanes01, out_p1_lanes23,
           out_p2_lanes01, out_p2_lanes23, fault_seen,
    output ready
  );
endinterface

// ===== rtl/core/xpc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// xpc_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface xpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [xpc_pkg::CFG_IDX_W-1:0]  index;
  logic [xpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/xoodoo_permutation_parity_checked_top.sv =====
// ----------------------------------------------------------------------------
// xoodoo_permutation_parity_checked_top
// iterative xoodoo-384 permutation with predicted column parity checking
// ----------------------------------------------------------------------------
//  channel  dir  handshake     word
//  feed     in   valid/ready   six 64-bit words, one full state
//  result   out  valid/ready   six 64-bit words plus fault_seen
//  cfg      in   valid/ready   index 0 round_count, index 1 check_enable
//
//  the state is loaded, then goes one round per cycle through the shared
//  round unit for n rounds (twelve by default); when n is zero it goes
//  straight to the done state; when the output register is still occupied
//  at the end the state waits in the done state until that register frees
//  feed is ready only while idle; the output register holds one finished
//  word so the next state can be loaded while the result waits
//  synchronous active-high reset; config is always ready
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xoodoo_permutation_parity_checked_top (
  input  logic         clk,
  input  logic         rst,
  xpc_feed_if.sink     feed,
  xpc_result_if.source result,
  xpc_cfg_if.sink      cfg
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                  state;
  xpc_pkg::lanes_t             lanes;
  xpc_pkg::parity_t            parity;
  logic [xpc_pkg::RIDX_W-1:0]  round_index;
  logic                        fault_latch;
  logic [3:0]                  round_count;
  logic                        check_enable;
  logic                        out_valid;
  xpc_pkg::lanes_t             out_lanes;
  logic                        out_fault;

  xpc_pkg::round_res_t         res;
  xpc_pkg::lanes_t             in_lanes;
  logic [xpc_pkg::RIDX_W-1:0]  rounds_eff;
  logic                        fault_next;
  logic                        slot_free;
  logic                        in_fire;

  assign in_fire    = feed.valid && feed.ready;
  assign slot_free  = !out_valid || result.ready;
  assign rounds_eff = (round_count > xpc_pkg::ROUNDS_MAX) ? xpc_pkg::ROUNDS_MAX
                                                          : round_count;
  assign fault_next = fault_latch | (check_enable & res.mismatch);

  always_comb begin
    in_lanes[0][0] = feed.in_p0_lanes01[31:0];
    in_lanes[0][1] = feed.in_p0_lanes01[63:32];
    in_lanes[0][2] = feed.in_p0_lanes23[31:0];
    in_lanes[0][3] = feed.in_p0_lanes23[63:32];
    in_lanes[1][0] = feed.in_p1_lanes01[31:0];
    in_lanes[1][1] = feed.in_p1_lanes01[63:32];
    in_lanes[1][2] = feed.in_p1_lanes23[31:0];
    in_lanes[1][3] = feed.in_p1_lanes23[63:32];
    in_lanes[2][0] = feed.in_p2_lanes01[31:0];
    in_lanes[2][1] = feed.in_p2_lanes01[63:32];
    in_lanes[2][2] = feed.in_p2_lanes23[31:0];
    in_lanes[2][3] = feed.in_p2_lanes23[63:32];
  end

  xpc_round u_round (
    .lanes  (lanes),
    .parity (parity),
    .rc     (xpc_pkg::round_const(round_index)),
    .res    (res)
  );

  assign feed.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count  <= xpc_pkg::RC_RESET;
      check_enable <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        xpc_pkg::CFG_ROUND_COUNT:  round_count  <= cfg.data;
        xpc_pkg::CFG_CHECK_ENABLE: check_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sequencer and working state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      round_index <= '0;
      fault_latch <= 1'b0;
      lanes       <= '0;
      parity      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            lanes       <= in_lanes;
            fault_latch <= 1'b0;
            for (int x = 0; x < 4; x++) begin
              parity[x] <= in_lanes[0][x] ^ in_lanes[1][x] ^ in_lanes[2][x];
            end
            round_index <= xpc_pkg::ROUNDS_MAX - rounds_eff;
            state       <= (rounds_eff == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          lanes       <= res.lanes;
          parity      <= res.parity;
          fault_latch <= fault_next;
          round_index <= round_index + 1'b1;
          if (round_index == xpc_pkg::ROUND_LAST) begin
            state <= slot_free ? S_IDLE : S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RUN && round_index == xpc_pkg::ROUND_LAST && slot_free) begin
      out_valid <= 1'b1;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RUN && round_index == xpc_pkg::ROUND_LAST && slot_free) begin
      out_lanes <= res.lanes;
      out_fault <= fault_next;
    end else if (state == S_DONE && slot_free) begin
      out_lanes <= lanes;
      out_fault <= fault_latch;
    end
  end

  assign result.valid          = out_valid;
  assign result.out_p0_lanes01 = {out_lanes[0][1], out_lanes[0][0]};
  assign result.out_p0_lanes23 = {out_lanes[0][3], out_lanes[0][2]};
  assign result.out_p1_lanes01 = {out_lanes[1][1], out_lanes[1][0]};
  assign result.out_p1_lanes23 = {out_lanes[1][3], out_lanes[1][2]};
  assign result.out_p2_lanes01 = {out_lanes[2][1], out_lanes[2][0]};
  assign result.out_p2_lanes23 = {out_lanes[2][3], out_lanes[2][2]};
  assign result.fault_seen     = out_fault;

  `XPC_ASSERT_IMPL(a_run_index_in_range, clk, rst, state == S_RUN, round_index <= xpc_pkg::ROUND_LAST)
  `XPC_ASSERT_NEXT(a_zero_rounds_skip, clk, rst, in_fire && rounds_eff == '0, state == S_DONE)
  `XPC_ASSERT_NEXT(a_first_round_index, clk, rst, in_fire && rounds_eff != '0, round_index == xpc_pkg::ROUNDS_MAX - $past(rounds_eff))
  `XPC_ASSERT_NEXT(a_no_check_no_fault, clk, rst, state == S_RUN && !check_enable, fault_latch == $past(fault_latch))

endmodule

// ===== rtl/core/xpc_round.sv =====
// ----------------------------------------------------------------------------
// xpc_round
// one xoodoo round with predicted column parity and per-step parity check
// ----------------------------------------------------------------------------
module xpc_round (
  input  xpc_pkg::lanes_t     lanes,
  input  xpc_pkg::parity_t    parity,
  input  xpc_pkg::lane_t      rc,
  output xpc_pkg::round_res_t res
);

  function automatic xpc_pkg::lane_t rotl(xpc_pkg::lane_t v, int unsigned r);
    return (v << r) | (v >> (xpc_pkg::LANE_W - r));
  endfunction

  // any column whose plane xor differs from the predicted parity
  function automatic logic col_bad(xpc_pkg::lanes_t s, xpc_pkg::parity_t p);
    logic bad;
    bad = 1'b0;
    for (int x = 0; x < 4; x++) begin
      if ((s[0][x] ^ s[1][x] ^ s[2][x]) != p[x]) bad = 1'b1;
    end
    return bad;
  endfunction

  always_comb begin
    xpc_pkg::lanes_t  a;
    xpc_pkg::parity_t p;
    xpc_pkg::parity_t e;
    xpc_pkg::plane_t  a1;
    xpc_pkg::plane_t  a2;
    xpc_pkg::plane_t  n1;
    xpc_pkg::plane_t  n2;
    xpc_pkg::lane_t   b0;
    xpc_pkg::lane_t   b1;
    xpc_pkg::lane_t   b2;
    logic             bad;

    a   = lanes;
    p   = parity;
    bad = 1'b0;

    // theta, driven by the predicted parity
    for (int x = 0; x < 4; x++) begin
      e[x] = rotl(p[(x + 3) % 4], xpc_pkg::THETA_ROT_A)
           ^ rotl(p[(x + 3) % 4], xpc_pkg::THETA_ROT_B);
    end
    for (int x = 0; x < 4; x++) begin
      a[0][x] = a[0][x] ^ e[x];
      a[1][x] = a[1][x] ^ e[x];
      a[2][x] = a[2][x] ^ e[x];
      p[x]    = p[x] ^ e[x];
    end
    bad = bad | col_bad(a, p);

    // rho-west
    a1 = a[1];
    a2 = a[2];
    for (int x = 0; x < 4; x++) begin
      n1[x] = a1[(x + 3) % 4];
      n2[x] = rotl(a2[x], xpc_pkg::RHO_WEST_ROT);
      p[x]  = p[x] ^ a1[x] ^ a2[x] ^ n1[x] ^ n2[x];
    end
    a[1] = n1;
    a[2] = n2;
    bad = bad | col_bad(a, p);

    // iota
    a[0][0] = a[0][0] ^ rc;
    p[0]    = p[0] ^ rc;
    bad = bad | col_bad(a, p);

    // chi
    for (int x = 0; x < 4; x++) begin
      b0 = ~a[1][x] & a[2][x];
      b1 = ~a[2][x] & a[0][x];
      b2 = ~a[0][x] & a[1][x];
      a[0][x] = a[0][x] ^ b0;
      a[1][x] = a[1][x] ^ b1;
      a[2][x] = a[2][x] ^ b2;
      p[x]    = p[x] ^ b0 ^ b1 ^ b2;
    end
    bad = bad | col_bad(a, p);

    // rho-east
    a1 = a[1];
    a2 = a[2];
    for (int x = 0; x < 4; x++) begin
      n1[x] = rotl(a1[x], xpc_pkg::RHO_EAST_ROT_A);
      n2[x] = rotl(a2[(x + 2) % 4], xpc_pkg::RHO_EAST_ROT_B);
      p[x]  = p[x] ^ a1[x] ^ a2[x] ^ n1[x] ^ n2[x];
    end
    a[1] = n1;
    a[2] = n2;
    bad = bad | col_bad(a, p);

    res.lanes    = a;
    res.parity   = p;
    res.mismatch = bad;
  end

endmodule
